[rtl/core/rgbypbpr_pkg.sv]
// ----------------------------------------------------------------------------
// rgbypbpr_pkg
// Shared widths, matrix coefficients and stage payload types for the
// BT.601 RGB / YPbPr converter.
// ----------------------------------------------------------------------------
package rgbypbpr_pkg;

   localparam int FRAC_BITS = 14;          // fractional bits of Y, Pb, Pr

   localparam int DATA_W = 16;
   localparam int NUM_CH = 3;
   localparam int TDATA_W = NUM_CH * DATA_W;

   // forward coefficients need FRAC_BITS+9 signed bits, reverse ones 26
   localparam int COEF_W = (FRAC_BITS + 10 > 26) ? FRAC_BITS + 10 : 26;
   localparam int PROD_W = COEF_W + DATA_W;
   // holds every product and every three-term sum in either direction
   localparam int ACC_W = (FRAC_BITS + 19 > 43) ? FRAC_BITS + 19 : 43;
   localparam int REV_SHIFT = FRAC_BITS + 16;

   localparam logic DIR_FWD = 1'b0;
   localparam logic DIR_REV = 1'b1;

   // forward: round(c * 2^(FRAC_BITS+16) / 255), c given in millionths
   localparam longint unsigned FWD_SCALE = 64'd1 << (FRAC_BITS + 16);
   localparam longint FWD_299 =
      longint'((FWD_SCALE * 64'd299000 + 64'd127500000) / 64'd255000000);
   localparam longint FWD_587 =
      longint'((FWD_SCALE * 64'd587000 + 64'd127500000) / 64'd255000000);
   localparam longint FWD_114 =
      longint'((FWD_SCALE * 64'd114000 + 64'd127500000) / 64'd255000000);
   localparam longint FWD_168 =
      longint'((FWD_SCALE * 64'd168736 + 64'd127500000) / 64'd255000000);
   localparam longint FWD_331 =
      longint'((FWD_SCALE * 64'd331264 + 64'd127500000) / 64'd255000000);
   localparam longint FWD_500 =
      longint'((FWD_SCALE * 64'd500000 + 64'd127500000) / 64'd255000000);
   localparam longint FWD_418 =
      longint'((FWD_SCALE * 64'd418688 + 64'd127500000) / 64'd255000000);
   localparam longint FWD_081 =
      longint'((FWD_SCALE * 64'd81312 + 64'd127500000) / 64'd255000000);

   // reverse: round(c * 255 * 2^16)
   localparam longint REV_1000 =
      longint'((64'd1000000 * 64'd16711680 + 64'd500000) / 64'd1000000);
   localparam longint REV_1402 =
      longint'((64'd1402000 * 64'd16711680 + 64'd500000) / 64'd1000000);
   localparam longint REV_0344 =
      longint'((64'd344136 * 64'd16711680 + 64'd500000) / 64'd1000000);
   localparam longint REV_0714 =
      longint'((64'd714136 * 64'd16711680 + 64'd500000) / 64'd1000000);
   localparam longint REV_1772 =
      longint'((64'd1772000 * 64'd16711680 + 64'd500000) / 64'd1000000);

   // matrix entry, row = output channel, column = input channel
   function automatic logic signed [COEF_W-1:0] coef_sel(input logic dir,
                                                         input logic [1:0] row,
                                                         input logic [1:0] col);
      longint k;
      k = 0;
      if (dir == DIR_FWD) begin
         unique case ({row, col})
            4'b0000: k = FWD_299;
            4'b0001: k = FWD_587;
            4'b0010: k = FWD_114;
            4'b0100: k = -FWD_168;
            4'b0101: k = -FWD_331;
            4'b0110: k = FWD_500;
            4'b1000: k = FWD_500;
            4'b1001: k = -FWD_418;
            4'b1010: k = -FWD_081;
            default: k = 0;
         endcase
      end else begin
         unique case ({row, col})
            4'b0000: k = REV_1000;
            4'b0001: k = 0;
            4'b0010: k = REV_1402;
            4'b0100: k = REV_1000;
            4'b0101: k = -REV_0344;
            4'b0110: k = -REV_0714;
            4'b1000: k = REV_1000;
            4'b1001: k = REV_1772;
            4'b1010: k = 0;
            default: k = 0;
         endcase
      end
      return COEF_W'(k);
   endfunction

   typedef struct packed {
      logic                     dir;
      logic signed [DATA_W-1:0] op_a;
      logic signed [DATA_W-1:0] op_b;
      logic signed [DATA_W-1:0] op_c;
   } operand_type;

   typedef struct packed {
      logic                                   dir;
      logic [NUM_CH*NUM_CH-1:0][ACC_W-1:0]    prod;   // row * 3 + col
   } product_type;

   typedef struct packed {
      logic                          dir;
      logic [NUM_CH-1:0][ACC_W-1:0]  acc;
   } sum_type;

endpackage

[rtl/core/rgbypbpr_operand.sv]
// ----------------------------------------------------------------------------
// rgbypbpr_operand
// First stage: conditions the three input fields (byte saturation in the
// forward direction) and tags them with the direction.
// ----------------------------------------------------------------------------
module rgbypbpr_operand (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  dir,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  logic [rgbypbpr_pkg::TDATA_W-1:0]      up_data,
   output logic                                  dn_valid,
   input  logic                                  dn_ready,
   output rgbypbpr_pkg::operand_type             dn_data
);

   logic                          valid_ff;
   rgbypbpr_pkg::operand_type     data_ff;
   rgbypbpr_pkg::operand_type     data_in;

   function automatic logic signed [rgbypbpr_pkg::DATA_W-1:0] cond(
         input logic d, input logic signed [rgbypbpr_pkg::DATA_W-1:0] x);
      logic signed [rgbypbpr_pkg::DATA_W-1:0] r;
      r = x;
      if (d == rgbypbpr_pkg::DIR_FWD) begin
         if (x < 0)
            r = '0;
         else if (x > 255)
            r = rgbypbpr_pkg::DATA_W'(255);
      end
      return r;
   endfunction

   always_comb begin
      data_in.dir  = dir;
      data_in.op_a = cond(dir, up_data[rgbypbpr_pkg::DATA_W-1:0]);
      data_in.op_b = cond(dir, up_data[2*rgbypbpr_pkg::DATA_W-1:rgbypbpr_pkg::DATA_W]);
      data_in.op_c = cond(dir, up_data[3*rgbypbpr_pkg::DATA_W-1:2*rgbypbpr_pkg::DATA_W]);
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[rtl/core/rgbypbpr_product.sv]
// ----------------------------------------------------------------------------
// rgbypbpr_product
// Second stage: the nine matrix products, one multiplier per entry.
// ----------------------------------------------------------------------------
module rgbypbpr_product (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  rgbypbpr_pkg::operand_type     up_data,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output rgbypbpr_pkg::product_type     dn_data
);

   logic                                     valid_ff;
   rgbypbpr_pkg::product_type                data_ff;
   rgbypbpr_pkg::product_type                data_in;
   logic signed [rgbypbpr_pkg::DATA_W-1:0]   opnd [rgbypbpr_pkg::NUM_CH];
   logic signed [rgbypbpr_pkg::PROD_W-1:0]   prod_full [rgbypbpr_pkg::NUM_CH*rgbypbpr_pkg::NUM_CH];

   always_comb begin
      opnd[0] = up_data.op_a;
      opnd[1] = up_data.op_b;
      opnd[2] = up_data.op_c;
      data_in.dir = up_data.dir;
      for (int r = 0; r < rgbypbpr_pkg::NUM_CH; r++) begin
         for (int c = 0; c < rgbypbpr_pkg::NUM_CH; c++) begin
            prod_full[r*rgbypbpr_pkg::NUM_CH + c] =
               rgbypbpr_pkg::PROD_W'(rgbypbpr_pkg::coef_sel(up_data.dir, 2'(r), 2'(c)))
               * rgbypbpr_pkg::PROD_W'(opnd[c]);
            data_in.prod[r*rgbypbpr_pkg::NUM_CH + c] =
               rgbypbpr_pkg::ACC_W'(prod_full[r*rgbypbpr_pkg::NUM_CH + c]);
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[rtl/core/rgbypbpr_sum.sv]
// ----------------------------------------------------------------------------
// rgbypbpr_sum
// Third stage: adds the three products of each matrix row.
// ----------------------------------------------------------------------------
module rgbypbpr_sum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  rgbypbpr_pkg::product_type     up_data,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output rgbypbpr_pkg::sum_type         dn_data
);

   logic                        valid_ff;
   rgbypbpr_pkg::sum_type       data_ff;
   rgbypbpr_pkg::sum_type       data_in;

   always_comb begin
      data_in.dir = up_data.dir;
      for (int r = 0; r < rgbypbpr_pkg::NUM_CH; r++) begin
         data_in.acc[r] = rgbypbpr_pkg::ACC_W'(
              $signed(up_data.prod[r*rgbypbpr_pkg::NUM_CH])
            + $signed(up_data.prod[r*rgbypbpr_pkg::NUM_CH + 1])
            + $signed(up_data.prod[r*rgbypbpr_pkg::NUM_CH + 2]));
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[rtl/core/rgbypbpr_format.sv]
// ----------------------------------------------------------------------------
// rgbypbpr_format
// Last stage and output register: rounds and saturates to Q1.14 forward,
// clamps to a byte in reverse.
// ----------------------------------------------------------------------------
module rgbypbpr_format (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  rgbypbpr_pkg::sum_type                 up_data,
   output logic                                  dn_valid,
   input  logic                                  dn_ready,
   output logic [rgbypbpr_pkg::TDATA_W-1:0]      dn_data
);

   logic                                                   valid_ff;
   logic [rgbypbpr_pkg::NUM_CH-1:0][rgbypbpr_pkg::DATA_W-1:0] data_ff;
   logic [rgbypbpr_pkg::NUM_CH-1:0][rgbypbpr_pkg::DATA_W-1:0] data_in;

   function automatic logic [rgbypbpr_pkg::DATA_W-1:0] fmt(
         input logic d, input logic signed [rgbypbpr_pkg::ACC_W-1:0] acc);
      logic signed [rgbypbpr_pkg::ACC_W-1:0] w;
      logic signed [rgbypbpr_pkg::ACC_W-1:0] q;
      logic [rgbypbpr_pkg::DATA_W-1:0]       r;
      w = acc + rgbypbpr_pkg::ACC_W'(32768);
      w = w >>> 16;                       // round half up, then floor
      q = acc >>> rgbypbpr_pkg::REV_SHIFT;
      if (d == rgbypbpr_pkg::DIR_FWD) begin
         if (w > rgbypbpr_pkg::ACC_W'(32767))
            r = 16'h7FFF;
         else if (w < rgbypbpr_pkg::ACC_W'(-32768))
            r = 16'h8000;
         else
            r = w[rgbypbpr_pkg::DATA_W-1:0];
      end else begin
         if (acc < 0)
            r = '0;
         else if (q > rgbypbpr_pkg::ACC_W'(255))
            r = rgbypbpr_pkg::DATA_W'(255);
         else
            r = rgbypbpr_pkg::DATA_W'(q[7:0]);
      end
      return r;
   endfunction

   always_comb begin
      for (int c = 0; c < rgbypbpr_pkg::NUM_CH; c++) begin
         data_in[c] = fmt(up_data.dir, $signed(up_data.acc[c]));
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[rtl/core/rgb_ypbpr_color_convert_top.sv]
// ----------------------------------------------------------------------------
// rgb_ypbpr_color_convert_top
// BT.601 RGB <-> YPbPr pixel converter with a direction register.
// ----------------------------------------------------------------------------
// One pixel per clock unless rsp_tready holds it back; each pixel passes four
// register stages (operand conditioning, nine multipliers, row adders,
// rounding/clamp into the output register). They stall together from rsp_tready;
// a stage with a bubble still accepts. Direction 0 takes red, green, blue
// (saturated to 0..255) and gives Y, Pb, Pr in signed Q1.14, rounded to
// nearest; direction 1 takes Y, Pb, Pr in Q1.14 and gives clamped, truncated
// bytes. Direction is sampled per pixel on entry; write it only while idle.
// ----------------------------------------------------------------------------
module rgb_ypbpr_color_convert_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_data,     // direction
   // pixel in
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rgbypbpr_pkg::TDATA_W-1:0]      req_tdata,    // in_a, in_b, in_c
   // pixel out
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rgbypbpr_pkg::TDATA_W-1:0]      rsp_tdata     // out_a, out_b, out_c
);

   logic                          direction_ff;
   logic                          direction_in;

   logic                          opnd_valid;
   logic                          opnd_ready;
   rgbypbpr_pkg::operand_type     opnd_data;
   logic                          prod_valid;
   logic                          prod_ready;
   rgbypbpr_pkg::product_type     prod_data;
   logic                          sum_valid;
   logic                          sum_ready;
   rgbypbpr_pkg::sum_type         sum_data;

   assign csr_ready    = 1'b1;
   assign direction_in = (csr_valid && csr_ready) ? csr_data : direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= rgbypbpr_pkg::DIR_FWD;
      end else begin
         direction_ff <= direction_in;
      end
   end

   rgbypbpr_operand u_operand (
      .clock    (clock),
      .reset    (reset),
      .dir      (direction_ff),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_data  (req_tdata),
      .dn_valid (opnd_valid),
      .dn_ready (opnd_ready),
      .dn_data  (opnd_data)
   );

   rgbypbpr_product u_product (
      .clock    (clock),
      .reset    (reset),
      .up_valid (opnd_valid),
      .up_ready (opnd_ready),
      .up_data  (opnd_data),
      .dn_valid (prod_valid),
      .dn_ready (prod_ready),
      .dn_data  (prod_data)
   );

   rgbypbpr_sum u_sum (
      .clock    (clock),
      .reset    (reset),
      .up_valid (prod_valid),
      .up_ready (prod_ready),
      .up_data  (prod_data),
      .dn_valid (sum_valid),
      .dn_ready (sum_ready),
      .dn_data  (sum_data)
   );

   rgbypbpr_format u_format (
      .clock    (clock),
      .reset    (reset),
      .up_valid (sum_valid),
      .up_ready (sum_ready),
      .up_data  (sum_data),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_data  (rsp_tdata)
   );

endmodule

[verif/rgb_ypbpr_color_convert_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_ypbpr_color_convert_top_tb
// Self-checking bench for the BT.601 RGB / YPbPr converter. Pixels are driven
// in both directions with random gaps and output back-pressure. Each accepted
// pixel is converted by a bit-exact integer model, and every output transfer
// is compared field by field with the oldest expected pixel.
// ----------------------------------------------------------------------------
module rgb_ypbpr_color_convert_top_tb;

   localparam int STALL_LIMIT  = 2000;   // cycles with no transfer at all
   localparam int DRAIN_CYCLES = 8;      // four-stage pipe, with margin
   localparam int PHASE_PIXELS = 225;
   localparam int SHIFT_OUT    = rgbypbpr_pkg::FRAC_BITS + 16;

   // c in millionths, 255 folded in, 16 extra fractional bits
   function automatic longint fwd_coef(input longint unsigned millionths);
      return longint'(((millionths << (rgbypbpr_pkg::FRAC_BITS + 16)) + 64'd127500000)
                      / 64'd255000000);
   endfunction

   function automatic longint rev_coef(input longint unsigned millionths);
      return longint'((millionths * 64'd16711680 + 64'd500000) / 64'd1000000);
   endfunction

   localparam longint K_YR   = fwd_coef(299000);
   localparam longint K_YG   = fwd_coef(587000);
   localparam longint K_YB   = fwd_coef(114000);
   localparam longint K_BR   = fwd_coef(168736);
   localparam longint K_BG   = fwd_coef(331264);
   localparam longint K_HALF = fwd_coef(500000);
   localparam longint K_RG   = fwd_coef(418688);
   localparam longint K_RB   = fwd_coef(81312);
   localparam longint K_ONE  = rev_coef(1000000);
   localparam longint K_RV   = rev_coef(1402000);
   localparam longint K_GU   = rev_coef(344136);
   localparam longint K_GV   = rev_coef(714136);
   localparam longint K_BU   = rev_coef(1772000);

   // field a in the lowest bits
   typedef struct packed {
      logic [rgbypbpr_pkg::DATA_W-1:0] c;
      logic [rgbypbpr_pkg::DATA_W-1:0] b;
      logic [rgbypbpr_pkg::DATA_W-1:0] a;
   } pixel_type;

   class colour_checker;
      logic         direction = rgbypbpr_pkg::DIR_FWD;
      pixel_type    expected_pixels[$];
      int unsigned  errors = 0;

      function longint in_byte(input logic [rgbypbpr_pkg::DATA_W-1:0] v);
         longint x;
         x = longint'($signed(v));
         if (x < 0) return 0;
         if (x > 255) return 255;
         return x;
      endfunction

      // round to nearest, ties up, then saturate to 16 signed bits
      function logic [rgbypbpr_pkg::DATA_W-1:0] fwd_round(input longint acc);
         longint w;
         w = (acc + 32768) >>> 16;
         if (w > 32767) w = 32767;
         if (w < -32768) w = -32768;
         return w[rgbypbpr_pkg::DATA_W-1:0];
      endfunction

      function logic [rgbypbpr_pkg::DATA_W-1:0] rev_byte(input longint acc);
         longint w;
         if (acc < 0) return '0;
         w = acc >>> SHIFT_OUT;
         if (w > 255) w = 255;
         return w[rgbypbpr_pkg::DATA_W-1:0];
      endfunction

      function pixel_type convert_pixel(input pixel_type p);
         longint r, g, bl, y, pb, pr;
         pixel_type q;
         if (direction == rgbypbpr_pkg::DIR_FWD) begin
            r  = in_byte(p.a);
            g  = in_byte(p.b);
            bl = in_byte(p.c);
            q.a = fwd_round(K_YR * r + K_YG * g + K_YB * bl);
            q.b = fwd_round(-K_BR * r - K_BG * g + K_HALF * bl);
            q.c = fwd_round(K_HALF * r - K_RG * g - K_RB * bl);
         end else begin
            y  = longint'($signed(p.a));
            pb = longint'($signed(p.b));
            pr = longint'($signed(p.c));
            q.a = rev_byte(K_ONE * y + K_RV * pr);
            q.b = rev_byte(K_ONE * y - K_GU * pb - K_GV * pr);
            q.c = rev_byte(K_ONE * y + K_BU * pb);
         end
         return q;
      endfunction

      function void note_pixel(input logic [rgbypbpr_pkg::TDATA_W-1:0] word);
         expected_pixels.push_back(convert_pixel(pixel_type'(word)));
      endfunction

      function void check_pixel(input logic [rgbypbpr_pkg::TDATA_W-1:0] word);
         pixel_type want, got;
         got = pixel_type'(word);
         if (expected_pixels.size() == 0) begin
            $error("unexpected output transfer: %h", word);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got.a !== want.a) begin
            $error("out_a: expected %0d, got %0d", $signed(want.a), $signed(got.a));
            errors++;
         end
         if (got.b !== want.b) begin
            $error("out_b: expected %0d, got %0d", $signed(want.b), $signed(got.b));
            errors++;
         end
         if (got.c !== want.c) begin
            $error("out_c: expected %0d, got %0d", $signed(want.c), $signed(got.c));
            errors++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_valid;
   logic                             csr_ready;
   logic                             csr_data;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [rgbypbpr_pkg::TDATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [rgbypbpr_pkg::TDATA_W-1:0] rsp_tdata;

   logic               steady = 1'b0;    // no gaps on either side while set
   colour_checker      colour_sb = new();

   rgb_ypbpr_color_convert_top uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) colour_sb.direction = csr_data;
         if (req_tvalid && req_tready) colour_sb.note_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) colour_sb.check_pixel(rsp_tdata);
      end
   end

   // output back-pressure
   initial begin
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) hold = gap_len();
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // handshake state is sampled at the falling edge, where it is settled
   task automatic send_pixel(input logic [rgbypbpr_pkg::DATA_W-1:0] a,
                             input logic [rgbypbpr_pkg::DATA_W-1:0] b,
                             input logic [rgbypbpr_pkg::DATA_W-1:0] c);
      int  gap;
      logic took;
      gap = steady ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c, b, a};
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
   endtask

   // stop sending and let every outstanding pixel come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (colour_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(input logic dir);
      logic took;
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= dir;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [rgbypbpr_pkg::DATA_W-1:0] fwd_field();
      if ($urandom_range(0, 9) < 8) return rgbypbpr_pkg::DATA_W'($urandom_range(0, 255));
      return rgbypbpr_pkg::DATA_W'($urandom);
   endfunction

   // in-range Y / Pb / Pr half of the time, some overrange, some anything
   function automatic logic [rgbypbpr_pkg::DATA_W-1:0] rev_field(input bit luma);
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return luma ? rgbypbpr_pkg::DATA_W'($urandom_range(0, 16384))
                     : rgbypbpr_pkg::DATA_W'(int'($urandom_range(0, 16384)) - 8192);
      if (r < 8) return rgbypbpr_pkg::DATA_W'(int'($urandom_range(0, 40000)) - 20000);
      return rgbypbpr_pkg::DATA_W'($urandom);
   endfunction

   initial begin
      logic phase_dir [6];
      phase_dir = '{rgbypbpr_pkg::DIR_FWD, rgbypbpr_pkg::DIR_REV, rgbypbpr_pkg::DIR_REV,
                    rgbypbpr_pkg::DIR_FWD, rgbypbpr_pkg::DIR_REV, rgbypbpr_pkg::DIR_FWD};
      reset      <= 1'b1;
      csr_valid  <= 1'b0;
      csr_data   <= 1'b0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_direction(rgbypbpr_pkg::DIR_FWD);
      send_pixel(16'd0, 16'd0, 16'd0);
      send_pixel(16'd255, 16'd255, 16'd255);
      send_pixel(16'd255, 16'd0, 16'd0);
      send_pixel(16'd0, 16'd255, 16'd0);
      send_pixel(16'd0, 16'd0, 16'd255);
      // inputs outside a byte saturate
      send_pixel(16'hFFFF, 16'd256, 16'h7FFF);
      send_pixel(16'h8000, 16'd300, 16'hFFFB);
      send_pixel(16'h7FFF, 16'h8000, 16'd128);
      send_pixel(16'h5555, 16'hAAAA, 16'h00FF);
      send_pixel(16'hAAAA, 16'h5555, 16'hFF00);
      send_pixel(16'd1, 16'd128, 16'd254);

      write_direction(rgbypbpr_pkg::DIR_REV);
      send_pixel(16'd0, 16'd0, 16'd0);
      send_pixel(16'd16384, 16'd0, 16'd0);
      // overrange clamps high and low
      send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_pixel(16'h8000, 16'h8000, 16'h8000);
      send_pixel(16'd16384, 16'hE000, 16'd8192);
      send_pixel(16'd0, 16'd8192, 16'hE000);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h5555, 16'hAAAA, 16'h5555);
      send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
      send_pixel(16'd8192, 16'h7FFF, 16'h8000);

      foreach (phase_dir[p]) begin
         write_direction(phase_dir[p]);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            if (n == 100) wait_idle();
            if (phase_dir[p] == rgbypbpr_pkg::DIR_FWD)
               send_pixel(fwd_field(), fwd_field(), fwd_field());
            else
               send_pixel(rev_field(1'b1), rev_field(1'b0), rev_field(1'b0));
         end
      end

      steady = 1'b0;
      wait_idle();
      if (colour_sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
